FILE: design/clfs_pkg.sv
// Package for the checksummed link frame sequencer: codes, types and the handshake ROM.
`default_nettype none

package clfs_pkg;

    localparam int PAYLOAD_MAX_DEF   = 32;
    localparam int HANDSHAKE_LEN_DEF = 47;

    localparam int CMD_W   = 3;
    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int PIDX_W  = 5;
    localparam int LEN_W   = 6;
    localparam int BIDX_W  = 7;
    localparam int OP_W    = 3;

    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RX_READY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NACK     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_WRITE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START_READ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEND_BYTE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEND_CSUM   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RESEND      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_STOP        = 3'd6;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND       = 3'd2;
    localparam logic [OP_W-1:0] OP_CSUM       = 3'd3;
    localparam logic [OP_W-1:0] OP_RESEND     = 3'd4;
    localparam logic [OP_W-1:0] OP_START_READ = 3'd5;
    localparam logic [OP_W-1:0] OP_RX         = 3'd6;
    localparam logic [OP_W-1:0] OP_CHECK      = 3'd7;

    localparam logic [0:0] CFG_TX_LEN = 1'b0;
    localparam logic [0:0] CFG_RX_LEN = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    localparam logic [BYTE_W-1:0] HS_ROM [64] = '{
        8'hCC, 8'h4C, 8'h65, 8'h74, 8'h27, 8'h73, 8'h20, 8'h73,
        8'h61, 8'h6D, 8'h62, 8'h61, 8'h20, 8'h6E, 8'h78, 8'h74,
        8'h20, 8'h61, 8'h72, 8'h6D, 8'h20, 8'h69, 8'h6E, 8'h20,
        8'h61, 8'h72, 8'h6D, 8'h2C, 8'h20, 8'h28, 8'h63, 8'h29,
        8'h4C, 8'h45, 8'h47, 8'h4F, 8'h20, 8'h53, 8'h79, 8'h73,
        8'h74, 8'h65, 8'h6D, 8'h20, 8'h41, 8'h2F, 8'h53, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ACT_W-1:0]  action;
        logic              from_rom;
        logic              byte_ok;
        logic [BYTE_W-1:0] rom_byte;
        logic [BYTE_W-1:0] data;
        logic              rx_valid;
        logic [PIDX_W-1:0] rx_index;
        logic              frame_done;
        logic              protocol_reset;
    } t_stage;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_valid;
        logic [PIDX_W-1:0] rx_index;
        logic [BYTE_W-1:0] rx_byte;
        logic              checksum_error;
        logic              frame_done;
        logic              protocol_reset;
    } t_result;

endpackage

`default_nettype wire

FILE: design/clfs_in_if.sv
// Event channel into the sequencer.
`default_nettype none

interface clfs_in_if import clfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic [PIDX_W-1:0] payload_index;

    modport source (output valid, output command, output data_byte, output payload_index,
                    input ready);
    modport sink (input valid, input command, input data_byte, input payload_index,
                  output ready);
endinterface

`default_nettype wire

FILE: design/clfs_out_if.sv
// Result channel out of the sequencer.
`default_nettype none

interface clfs_out_if import clfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_valid;
    logic [PIDX_W-1:0] rx_index;
    logic [BYTE_W-1:0] rx_byte;
    logic              checksum_error;
    logic              frame_done;
    logic              protocol_reset;

    modport source (output valid, output action, output tx_byte, output rx_valid,
                    output rx_index, output rx_byte, output checksum_error,
                    output frame_done, output protocol_reset, input ready);
    modport sink (input valid, input action, input tx_byte, input rx_valid,
                  input rx_index, input rx_byte, input checksum_error,
                  input frame_done, input protocol_reset, output ready);
endinterface

`default_nettype wire

FILE: design/clfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module clfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/checksummed_link_frame_sequencer.sv
// Top level of the checksummed link frame sequencer.
//
// The sequencer takes one bus event per transaction on i_in (command, data_byte,
// payload_index) and returns exactly one result transaction per event on o_out.
// Configuration writes set the transmit and receive payload lengths through
// i_cfg_we, i_cfg_idx and i_cfg_wdata, taken at once. The user must write them
// only while idle; the block does not enforce it. Each event reaches the output
// register through the second stage. The block accepts a new event every cycle
// unless stalled; the running sum and the last sent byte are updated in the
// second stage, next to the RAM read data, so no interlock is needed. When the
// receiver stalls, the result stays in the output register, the second stage
// may still fill, and i_in.ready drops once both are occupied. A synchronous
// reset puts the block in the reset phase, sets both lengths to 32 and marks
// every payload entry as reading zero; no clearing pass is run.
`default_nettype none

module checksummed_link_frame_sequencer import clfs_pkg::*; #(
    parameter int PAYLOAD_MAX   = PAYLOAD_MAX_DEF,
    parameter int HANDSHAKE_LEN = HANDSHAKE_LEN_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    clfs_in_if.sink               i_in,
    clfs_out_if.source            o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_idx,
    input  wire logic [LEN_W-1:0] i_cfg_wdata
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    localparam logic [2:0] PH_RESET     = 3'd0;
    localparam logic [2:0] PH_SENDING   = 3'd1;
    localparam logic [2:0] PH_RECEIVE   = 3'd2;
    localparam logic [2:0] PH_RECEIVING = 3'd3;
    localparam logic [2:0] PH_SEND      = 3'd4;

    localparam logic [BIDX_W-1:0] MAX_LEN = BIDX_W'(PAYLOAD_MAX);
    localparam logic [BIDX_W-1:0] HS_LEN  = BIDX_W'(HANDSHAKE_LEN);

    logic [LEN_W-1:0]  r_tx_len;
    logic [LEN_W-1:0]  r_rx_len;
    logic [2:0]        r_phase, n_phase;
    logic [BIDX_W-1:0] r_bidx, n_bidx;
    logic              r_drop, n_drop;
    logic              r_hs, n_hs;
    logic [PAYLOAD_MAX-1:0] r_pvalid;

    logic              r_s2_v;
    t_stage            r_s2, n_s2;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_last, n_last;
    logic              r_out_v;
    t_result           r_out, n_out;

    logic              in_fire;
    logic              s2_fire;
    logic              rd_en;
    logic [BIDX_W-1:0] rd_idx;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BIDX_W-1:0] tx_len;
    logic [BIDX_W-1:0] rx_len;
    logic [BIDX_W-1:0] bidx_inc;
    logic [BYTE_W-1:0] frame_b;
    logic [BYTE_W:0]   check_sum;

    function automatic logic [BIDX_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [BIDX_W-1:0] w;
        w = BIDX_W'(v);
        if (w == '0) begin
            return BIDX_W'(1);
        end else if (w > MAX_LEN) begin
            return MAX_LEN;
        end
        return w;
    endfunction

    assign s2_fire  = r_s2_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_s2_v || s2_fire;
    assign in_fire  = i_in.valid && i_in.ready;

    assign tx_len   = r_hs ? HS_LEN : clamp_len(r_tx_len);
    assign rx_len   = clamp_len(r_rx_len);
    assign bidx_inc = r_bidx + BIDX_W'(1);
    assign rd_addr  = ADDR_W'(rd_idx);
    assign wr_addr  = ADDR_W'({2'b00, i_in.payload_index});

    always_comb begin
        n_phase = r_phase;
        n_bidx  = r_bidx;
        n_drop  = r_drop;
        n_hs    = r_hs;
        rd_en   = 1'b0;
        rd_idx  = r_bidx;
        wr_en   = 1'b0;
        n_s2    = '0;
        n_s2.op     = OP_NONE;
        n_s2.action = ACT_NONE;
        n_s2.data   = i_in.data_byte;

        unique case (i_in.command)
            CMD_TICK: begin
                if (r_phase == PH_RESET || r_phase == PH_SEND) begin
                    n_hs        = (r_phase == PH_RESET);
                    n_phase     = PH_SENDING;
                    n_bidx      = BIDX_W'(1);
                    rd_en       = 1'b1;
                    rd_idx      = '0;
                    n_s2.op     = OP_SEND_FIRST;
                    n_s2.action = ACT_START_WRITE;
                    n_s2.from_rom = (r_phase == PH_RESET);
                end else if (r_phase == PH_RECEIVE) begin
                    n_phase     = PH_RECEIVING;
                    n_bidx      = '0;
                    n_drop      = 1'b1;
                    n_s2.op     = OP_START_READ;
                    n_s2.action = ACT_START_READ;
                end
            end
            CMD_TX_READY: begin
                if (r_phase != PH_SENDING) begin
                    n_phase = PH_RESET;
                    n_s2.protocol_reset = 1'b1;
                end else if (r_bidx == tx_len) begin
                    n_bidx      = bidx_inc;
                    n_s2.op     = OP_CSUM;
                    n_s2.action = ACT_SEND_CSUM;
                end else if (r_bidx > tx_len) begin
                    n_phase = PH_RECEIVE;
                    n_s2.frame_done = 1'b1;
                end else begin
                    n_bidx        = bidx_inc;
                    rd_en         = 1'b1;
                    n_s2.op       = OP_SEND;
                    n_s2.action   = ACT_SEND_BYTE;
                    n_s2.from_rom = r_hs;
                end
            end
            CMD_RX_READY: begin
                if (r_phase != PH_RECEIVING) begin
                    n_phase = PH_RESET;
                    n_s2.protocol_reset = 1'b1;
                end else if (r_drop) begin
                    n_drop = 1'b0;
                end else if (r_bidx >= rx_len) begin
                    n_phase = PH_SEND;
                    n_s2.op = OP_CHECK;
                    n_s2.frame_done = 1'b1;
                end else begin
                    n_bidx        = bidx_inc;
                    n_s2.op       = OP_RX;
                    n_s2.rx_valid = 1'b1;
                    n_s2.rx_index = r_bidx[PIDX_W-1:0];
                    if (bidx_inc == rx_len) begin
                        n_s2.action = ACT_STOP;
                    end
                end
            end
            CMD_NACK: begin
                n_s2.op     = OP_RESEND;
                n_s2.action = ACT_RESEND;
            end
            CMD_WRITE: begin
                wr_en = ({2'b00, i_in.payload_index} < MAX_LEN);
            end
            default: begin
            end
        endcase

        n_s2.rom_byte = HS_ROM[rd_idx[5:0]];
        n_s2.byte_ok  = (rd_idx < MAX_LEN) && r_pvalid[rd_addr];
    end

    clfs_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in.data_byte),
        .i_re    (in_fire && rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        frame_b   = r_s2.from_rom ? r_s2.rom_byte : (r_s2.byte_ok ? ram_rdata : '0);
        check_sum = {1'b0, r_sum} + {1'b0, r_s2.data};
        n_sum     = r_sum;
        n_last    = r_last;
        n_out     = '0;
        n_out.action         = r_s2.action;
        n_out.rx_valid       = r_s2.rx_valid;
        n_out.rx_index       = r_s2.rx_index;
        n_out.frame_done     = r_s2.frame_done;
        n_out.protocol_reset = r_s2.protocol_reset;

        unique case (r_s2.op)
            OP_NONE: begin
            end
            OP_SEND_FIRST: begin
                n_out.tx_byte = frame_b;
                n_sum  = frame_b;
                n_last = frame_b;
            end
            OP_SEND: begin
                n_out.tx_byte = frame_b;
                n_sum  = r_sum + frame_b;
                n_last = frame_b;
            end
            OP_CSUM: begin
                n_out.tx_byte = ~r_sum;
                n_last = ~r_sum;
            end
            OP_RESEND: begin
                n_out.tx_byte = r_last;
            end
            OP_START_READ: begin
                n_sum = '0;
            end
            OP_RX: begin
                n_out.rx_byte = r_s2.data;
                n_sum = r_sum + r_s2.data;
            end
            OP_CHECK: begin
                n_out.checksum_error = (check_sum != 9'h0FF);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_len <= LEN_RESET;
            r_rx_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TX_LEN: r_tx_len <= i_cfg_wdata;
                CFG_RX_LEN: r_rx_len <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RESET;
            r_bidx   <= '0;
            r_drop   <= 1'b0;
            r_hs     <= 1'b0;
            r_pvalid <= '0;
            r_s2_v   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_bidx  <= n_bidx;
                r_drop  <= n_drop;
                r_hs    <= n_hs;
                if (wr_en) begin
                    r_pvalid[wr_addr] <= 1'b1;
                end
                r_s2_v <= 1'b1;
            end else if (s2_fire) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_last  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (s2_fire) begin
                r_sum   <= n_sum;
                r_last  <= n_last;
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.action         = r_out.action;
    assign o_out.tx_byte        = r_out.tx_byte;
    assign o_out.rx_valid       = r_out.rx_valid;
    assign o_out.rx_index       = r_out.rx_index;
    assign o_out.rx_byte        = r_out.rx_byte;
    assign o_out.checksum_error = r_out.checksum_error;
    assign o_out.frame_done     = r_out.frame_done;
    assign o_out.protocol_reset = r_out.protocol_reset;

endmodule

`default_nettype wire

FILE: verif/checksummed_link_frame_sequencer_tb.sv
// Testbench for the checksummed link frame sequencer: random bus traffic checked against a predictor.
module checksummed_link_frame_sequencer_tb;
    import clfs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_CYCLES = 80;

    typedef enum logic [2:0] {
        SEQ_RESET,
        SEQ_SENDING,
        SEQ_RECEIVE,
        SEQ_RECEIVING,
        SEQ_SEND
    } t_seq_phase;

    typedef struct packed {
        t_seq_phase                                phase;
        logic [BIDX_W-1:0]                         byte_idx;
        logic [BYTE_W-1:0]                         sum;
        logic                                      drop_first;
        logic                                      handshake;
        logic [BYTE_W-1:0]                         last_sent;
        logic [LEN_W-1:0]                          tx_len;
        logic [LEN_W-1:0]                          rx_len;
        logic [PAYLOAD_MAX_DEF-1:0][BYTE_W-1:0]    store;
    } t_link_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        logic [PIDX_W-1:0] pidx;
    } t_bus_event;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [0:0] cfg_idx;
    logic [LEN_W-1:0] cfg_wdata;

    clfs_in_if in_ch ();
    clfs_out_if out_ch ();

    checksummed_link_frame_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    t_link_state seq_now;
    t_link_state stim_seq;
    t_bus_event bus_events[$];
    t_result due_results[$];
    t_result link_result;
    t_result want;
    t_bus_event next_event;
    int mismatch_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int results_seen = 0;
    int hold_left = 0;
    logic held = 1'b0;
    int quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [BIDX_W-1:0] clamped_length(input logic [LEN_W-1:0] v);
        if (v == '0) begin
            return BIDX_W'(1);
        end else if (BIDX_W'(v) > BIDX_W'(PAYLOAD_MAX_DEF)) begin
            return BIDX_W'(PAYLOAD_MAX_DEF);
        end
        return BIDX_W'(v);
    endfunction

    function automatic logic [BYTE_W-1:0] emit_frame_byte(inout t_link_state s);
        logic [BYTE_W-1:0] b;
        if (s.handshake) begin
            b = HS_ROM[s.byte_idx[5:0]];
        end else if (s.byte_idx < BIDX_W'(PAYLOAD_MAX_DEF)) begin
            b = s.store[s.byte_idx[PIDX_W-1:0]];
        end else begin
            b = '0;
        end
        s.sum = s.sum + b;
        s.byte_idx = s.byte_idx + 1'b1;
        s.last_sent = b;
        return b;
    endfunction

    function automatic t_result next_link_result(inout t_link_state s,
            input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
            input logic [PIDX_W-1:0] pidx);
        t_result r;
        logic [BIDX_W-1:0] len;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (s.phase == SEQ_RESET || s.phase == SEQ_SEND) begin
                    s.handshake = (s.phase == SEQ_RESET);
                    s.phase = SEQ_SENDING;
                    s.byte_idx = '0;
                    s.sum = '0;
                    r.action = ACT_START_WRITE;
                    r.tx_byte = emit_frame_byte(s);
                end else if (s.phase == SEQ_RECEIVE) begin
                    s.phase = SEQ_RECEIVING;
                    s.byte_idx = '0;
                    s.sum = '0;
                    s.drop_first = 1'b1;
                    r.action = ACT_START_READ;
                end
            end
            CMD_TX_READY: begin
                if (s.handshake) begin
                    len = BIDX_W'(HANDSHAKE_LEN_DEF);
                end else begin
                    len = clamped_length(s.tx_len);
                end
                if (s.phase != SEQ_SENDING) begin
                    s.phase = SEQ_RESET;
                    r.protocol_reset = 1'b1;
                end else if (s.byte_idx == len) begin
                    r.action = ACT_SEND_CSUM;
                    r.tx_byte = ~s.sum;
                    s.last_sent = ~s.sum;
                    s.byte_idx = s.byte_idx + 1'b1;
                end else if (s.byte_idx > len) begin
                    s.phase = SEQ_RECEIVE;
                    r.frame_done = 1'b1;
                end else begin
                    r.action = ACT_SEND_BYTE;
                    r.tx_byte = emit_frame_byte(s);
                end
            end
            CMD_RX_READY: begin
                len = clamped_length(s.rx_len);
                if (s.phase != SEQ_RECEIVING) begin
                    s.phase = SEQ_RESET;
                    r.protocol_reset = 1'b1;
                end else if (s.drop_first) begin
                    s.drop_first = 1'b0;
                end else if (s.byte_idx >= len) begin
                    r.checksum_error = (({1'b0, s.sum} + {1'b0, data}) != 9'h0FF);
                    r.frame_done = 1'b1;
                    s.phase = SEQ_SEND;
                end else begin
                    r.rx_valid = 1'b1;
                    r.rx_index = s.byte_idx[PIDX_W-1:0];
                    r.rx_byte = data;
                    s.sum = s.sum + data;
                    if (s.byte_idx + 1'b1 == len) begin
                        r.action = ACT_STOP;
                    end
                    s.byte_idx = s.byte_idx + 1'b1;
                end
            end
            CMD_NACK: begin
                r.action = ACT_RESEND;
                r.tx_byte = s.last_sent;
            end
            CMD_WRITE: begin
                s.store[pidx] = data;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
            input logic [PIDX_W-1:0] pidx);
        t_result unused;
        bus_events.push_back({cmd, data, pidx});
        unused = next_link_result(stim_seq, cmd, data, pidx);
    endtask

    // Mostly well-formed frames; the rest are payload writes, nacks, spare command codes and events out of phase.
    task automatic gen_traffic(input int count);
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [BYTE_W-1:0] data;
        logic [PIDX_W-1:0] pidx;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            data = BYTE_W'($urandom);
            pidx = PIDX_W'($urandom);
            if (roll < 90) begin
                case (stim_seq.phase)
                    SEQ_SENDING: begin
                        cmd = CMD_TX_READY;
                    end
                    SEQ_RECEIVING: begin
                        cmd = CMD_RX_READY;
                        if (!stim_seq.drop_first
                                && stim_seq.byte_idx >= clamped_length(stim_seq.rx_len)
                                && $urandom_range(0, 1)) begin
                            data = 8'hFF - stim_seq.sum;
                        end
                    end
                    default: begin
                        cmd = CMD_TICK;
                    end
                endcase
            end else if (roll < 95) begin
                cmd = CMD_WRITE;
            end else if (roll < 97) begin
                cmd = CMD_NACK;
            end else if (roll == 97) begin
                cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end else if (roll == 98) begin
                cmd = CMD_TICK;
            end else if (stim_seq.phase == SEQ_SENDING) begin
                cmd = CMD_RX_READY;
            end else if (stim_seq.phase == SEQ_RECEIVING) begin
                cmd = CMD_TX_READY;
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_TX_READY : CMD_RX_READY;
            end
            queue_event(cmd, data, pidx);
        end
    endtask

    task automatic write_length(input logic [0:0] idx, input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        if (idx == CFG_TX_LEN) begin
            seq_now.tx_len = value;
            stim_seq.tx_len = value;
        end else begin
            seq_now.rx_len = value;
            stim_seq.rx_len = value;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (bus_events.size() != 0 || in_ch.valid || due_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] expected,
            input logic [BYTE_W-1:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.command <= CMD_TICK;
            in_ch.data_byte <= '0;
            in_ch.payload_index <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                link_result = next_link_result(seq_now, in_ch.command, in_ch.data_byte,
                                               in_ch.payload_index);
                due_results.push_back(link_result);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (bus_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_event = bus_events.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.command <= next_event.cmd;
                    in_ch.data_byte <= next_event.data;
                    in_ch.payload_index <= next_event.pidx;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with no event pending: action %0d",
                           out_ch.action);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("action", want.action, out_ch.action);
                    check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
                    check_field("rx_valid", want.rx_valid, out_ch.rx_valid);
                    check_field("rx_index", want.rx_index, out_ch.rx_index);
                    check_field("rx_byte", want.rx_byte, out_ch.rx_byte);
                    check_field("checksum_error", want.checksum_error, out_ch.checksum_error);
                    check_field("frame_done", want.frame_done, out_ch.frame_done);
                    check_field("protocol_reset", want.protocol_reset, out_ch.protocol_reset);
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (results_seen == HOLD_AFTER && !held) begin
                hold_left <= HOLD_CYCLES;
                held <= 1'b1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [LEN_W-1:0] tx_len_v;
        logic [LEN_W-1:0] rx_len_v;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_TX_LEN;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_TICK;
        in_ch.data_byte = '0;
        in_ch.payload_index = '0;
        out_ch.ready = 1'b0;
        seq_now = '0;
        seq_now.phase = SEQ_RESET;
        seq_now.tx_len = LEN_RESET;
        seq_now.rx_len = LEN_RESET;
        stim_seq = seq_now;
        send_idle_pct = 13;
        recv_idle_pct = 56;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_event(CMD_NACK, 8'h00, 5'd0);
        queue_event(CMD_SPARE_LO, 8'hFF, 5'd31);
        queue_event(CMD_SPARE_MID, 8'h5A, 5'd10);
        queue_event(CMD_SPARE_HI, 8'hA5, 5'd21);
        queue_event(CMD_TX_READY, 8'hFF, 5'd31);
        queue_event(CMD_RX_READY, 8'h00, 5'd0);
        queue_event(CMD_WRITE, 8'hFF, 5'd31);
        queue_event(CMD_WRITE, 8'h00, 5'd0);
        queue_event(CMD_WRITE, 8'h81, 5'd1);
        queue_event(CMD_TICK, 8'hFF, 5'd31);
        queue_event(CMD_NACK, 8'h00, 5'd0);
        queue_event(CMD_TICK, 8'h00, 5'd0);
        queue_event(CMD_TX_READY, 8'h00, 5'd0);
        queue_event(CMD_RX_READY, 8'hFF, 5'd31);
        queue_event(CMD_NACK, 8'hFF, 5'd31);
        queue_event(CMD_TICK, 8'h00, 5'd0);
        queue_event(CMD_TX_READY, 8'hFF, 5'd31);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    tx_len_v = 6'd1;
                    rx_len_v = 6'd1;
                end
                1: begin
                    tx_len_v = 6'd32;
                    rx_len_v = 6'd32;
                end
                2: begin
                    tx_len_v = 6'd0;
                    rx_len_v = 6'd63;
                end
                3: begin
                    tx_len_v = 6'd63;
                    rx_len_v = 6'd0;
                end
                default: begin
                    tx_len_v = LEN_W'($urandom_range(0, 63));
                    rx_len_v = LEN_W'($urandom_range(0, 63));
                end
            endcase
            if (p == 2) begin
                send_idle_pct = 56;
                recv_idle_pct = 13;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_length(CFG_TX_LEN, tx_len_v);
            write_length(CFG_RX_LEN, rx_len_v);
            gen_traffic(240);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
design/clfs_pkg.sv
design/clfs_in_if.sv
design/clfs_out_if.sv
design/clfs_ram.sv
design/checksummed_link_frame_sequencer.sv
verif/checksummed_link_frame_sequencer_tb.sv
